[rtl/bfd_pkg.sv]
// Package: frame parser phase codes, status codes and the result type.
`timescale 1ns / 1ps

package bfd_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_CTRL  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_TAIL  = 3'd5;

    // Per-byte status codes
    localparam logic [2:0] ST_FRAMING  = 3'd0;
    localparam logic [2:0] ST_CMD      = 3'd1;
    localparam logic [2:0] ST_PAYLOAD  = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_HEAD_ERR = 3'd4;
    localparam logic [2:0] ST_CTRL_ERR = 3'd5;
    localparam logic [2:0] ST_TAIL_ERR = 3'd6;

    // Configuration register indexes
    localparam logic CFG_HEAD = 1'b0;
    localparam logic CFG_TAIL = 1'b1;

    // Control byte fields
    localparam logic [7:0] CTRL_TYPE_MASK = 8'hF0;
    localparam logic [7:0] CTRL_ID_MASK   = 8'h0F;

    // Length field is two bytes
    localparam logic [15:0] LEN_BYTES = 16'd2;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  sender_id;
        logic [15:0] frame_length;
        logic [7:0]  byte_value;
        logic [15:0] payload_index;
    } result_t;

endpackage

[rtl/bfd_if.sv]
// Interfaces: received byte channel and status result channel.
`timescale 1ns / 1ps

interface bfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface bfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  sender_id;
    logic [15:0] frame_length;
    logic [7:0]  byte_value;
    logic [15:0] payload_index;

    modport source (output valid, output status, output sender_id, output frame_length,
                    output byte_value, output payload_index, input ready);
    modport sink (input valid, input status, input sender_id, input frame_length,
                  input byte_value, input payload_index, output ready);
endinterface

[rtl/bfd_parser.sv]
// Frame parser: configuration registers, phase state and per-byte status logic.
`timescale 1ns / 1ps

module bfd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output bfd_pkg::result_t result
);
    import bfd_pkg::*;

    logic [7:0]  head_reg;
    logic [7:0]  tail_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] length_reg, length_next;
    logic [3:0]  sender_reg, sender_next;
    logic [15:0] count_inc;

    assign count_inc = count_reg + 16'd1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD: head_reg <= cfg_data;
                CFG_TAIL: tail_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Next state and status for the byte on the input
    always_comb
    begin
        logic as_check;
        as_check             = 1'b0;
        phase_next           = phase_reg;
        count_next           = count_reg;
        length_next          = length_reg;
        sender_next          = sender_reg;
        result.status        = ST_FRAMING;
        result.byte_value    = '0;
        result.payload_index = '0;

        unique case (phase_reg)
            PH_CTRL:
            begin
                if ((rx_byte & CTRL_TYPE_MASK) != 8'd0)
                begin
                    sender_next = 4'(rx_byte & CTRL_ID_MASK);
                    length_next = '0;
                    phase_next  = PH_LEN;
                end
                else
                begin
                    result.status = ST_CTRL_ERR;
                    phase_next    = PH_HEAD;
                end
            end
            PH_LEN:
            begin
                length_next = {length_reg[7:0], rx_byte};
                count_next  = count_inc;
                if (count_inc == LEN_BYTES)
                begin
                    phase_next = PH_DATA;
                    count_next = '0;
                end
            end
            PH_DATA:
            begin
                if (length_reg != 16'd0)
                begin
                    result.byte_value = rx_byte;
                    if (count_reg == 16'd0)
                        result.status = ST_CMD;
                    else
                    begin
                        result.status        = ST_PAYLOAD;
                        result.payload_index = count_reg - 16'd1;
                    end
                    count_next = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_CHECK;
                        count_next = '0;
                    end
                end
                else
                    as_check = 1'b1;
            end
            PH_CHECK:
                as_check = 1'b1;
            PH_TAIL:
            begin
                result.status = (rx_byte == tail_reg) ? ST_DONE : ST_TAIL_ERR;
                phase_next    = PH_HEAD;
            end
            default:
            begin
                // head phase, and the unused codes
                count_next  = '0;
                sender_next = '0;
                if (rx_byte == head_reg)
                    phase_next = PH_CTRL;
                else
                begin
                    result.status = ST_HEAD_ERR;
                    phase_next    = PH_HEAD;
                end
            end
        endcase

        // check byte is skipped
        if (as_check)
        begin
            count_next = '0;
            phase_next = PH_TAIL;
        end

        result.sender_id    = sender_next;
        result.frame_length = length_next;
    end

    // Parser state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            count_reg  <= '0;
            length_reg <= '0;
            sender_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            sender_reg <= sender_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_TAIL)
        else $error("parser phase left the legal range");

    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEN |-> count_reg < LEN_BYTES)
        else $error("length byte count overran");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> (count_reg < length_reg || length_reg == 16'd0))
        else $error("data byte count reached declared length");

    a_tail_return: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_TAIL |=> phase_reg == PH_HEAD)
        else $error("parser did not return to head after tail");
`endif

endmodule

[rtl/bfd_out_reg.sv]
// Result register: holds one status beat until the sink takes it.
`timescale 1ns / 1ps

module bfd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bfd_pkg::result_t result,
    output logic             can_load,
    bfd_out_if.source        out_ch
);
    import bfd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Free when empty or drained this cycle
    assign can_load = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load && can_load)
            data_reg <= result;
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.status        = data_reg.status;
    assign out_ch.sender_id     = data_reg.sender_id;
    assign out_ch.frame_length  = data_reg.frame_length;
    assign out_ch.byte_value    = data_reg.byte_value;
    assign out_ch.payload_index = data_reg.payload_index;

`ifndef NO_ASSERTIONS
    a_cmd_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (data_reg.status == ST_CMD || data_reg.status == ST_PAYLOAD)
        |-> data_reg.frame_length != 16'd0)
        else $error("data beat with zero frame length");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.status == ST_PAYLOAD
        |-> data_reg.payload_index < data_reg.frame_length - 16'd1)
        else $error("payload index beyond declared length");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.status != 3'd7)
        else $error("undefined status code");
`endif

endmodule

[rtl/byte_frame_deframer.sv]
// Top level: byte stream frame parser with one status beat per received byte.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    rx_byte[7:0]
//  out_ch   out  valid/ready    status, sender_id, frame_length, byte_value, payload_index
//  cfg      in   cfg_we         cfg_index (0 head, 1 tail), cfg_data[7:0]
//
// One byte per cycle while out_ch is not stalled; each status beat appears in the cycle after its byte is taken.
// Each status beat is held in the single result register after the phase logic.
// in_ch.ready is high while the result register is empty or being drained.
// A stalled out_ch holds its beat and stops intake; no beat is dropped.
// Reset clears the phase to head, counters, sender, and both config bytes.
`timescale 1ns / 1ps

module byte_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    bfd_in_if.sink     in_ch,
    bfd_out_if.source  out_ch
);
    import bfd_pkg::*;

    logic    can_load;
    logic    accept;
    result_t result;

    assign in_ch.ready = can_load;
    assign accept      = in_ch.valid && can_load;

    // Phase logic
    bfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (in_ch.rx_byte),
        .result    (result)
    );

    // Result register
    bfd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

[tb/bfd_frame_checker.sv]
// Frame parser checker: watches both channels, predicts each status beat, compares in order.
`timescale 1ns / 1ps

module bfd_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    bfd_in_if          in_mon,
    bfd_out_if         out_mon,
    output int         fail_count,
    output int         pending,
    output int         beats_checked,
    output int         done_count,
    output int         err_count
);
    import bfd_pkg::*;

    localparam int MAX_REPORTS = 50;

    // Shadow copy of the framing registers and the parser state
    logic [7:0]  head_val;
    logic [7:0]  tail_val;
    logic [2:0]  phase;
    logic [15:0] byte_cnt;
    logic [15:0] decl_len;
    logic [3:0]  sender;

    // Status beats predicted but not yet seen on the output
    result_t status_due[$];

    // Advance the parser by one received byte and return its status beat
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t    r;
        logic       to_tail;
        logic [7:0] id_bits;
        r         = '0;
        r.status  = ST_FRAMING;
        to_tail   = 1'b0;
        id_bits   = b & CTRL_ID_MASK;
        case (phase)
            PH_CTRL:
            begin
                if ((b & CTRL_TYPE_MASK) != 8'h00)
                begin
                    sender   = id_bits[3:0];
                    decl_len = 16'h0000;
                    phase    = PH_LEN;
                end
                else
                begin
                    r.status = ST_CTRL_ERR;
                    phase    = PH_HEAD;
                end
            end
            PH_LEN:
            begin
                // big-endian length, high byte first
                decl_len = {decl_len[7:0], b};
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt == LEN_BYTES)
                begin
                    phase    = PH_DATA;
                    byte_cnt = 16'h0000;
                end
            end
            PH_DATA:
            begin
                if (decl_len != 16'h0000)
                begin
                    r.byte_value = b;
                    if (byte_cnt == 16'h0000)
                        r.status = ST_CMD;
                    else
                    begin
                        r.status        = ST_PAYLOAD;
                        r.payload_index = byte_cnt - 16'd1;
                    end
                    byte_cnt = byte_cnt + 16'd1;
                    if (byte_cnt == decl_len)
                    begin
                        phase    = PH_CHECK;
                        byte_cnt = 16'h0000;
                    end
                end
                else
                    to_tail = 1'b1;  // empty frame: this byte is the check byte
            end
            PH_CHECK:
                to_tail = 1'b1;
            PH_TAIL:
            begin
                r.status = (b == tail_val) ? ST_DONE : ST_TAIL_ERR;
                phase    = PH_HEAD;
            end
            default:
            begin
                // head phase (and unused codes): counter and sender cleared first
                byte_cnt = 16'h0000;
                sender   = 4'h0;
                if (b == head_val)
                    phase = PH_CTRL;
                else
                begin
                    r.status = ST_HEAD_ERR;
                    phase    = PH_HEAD;
                end
            end
        endcase
        if (to_tail)
        begin
            byte_cnt = 16'h0000;
            phase    = PH_TAIL;
        end
        r.sender_id    = sender;
        r.frame_length = decl_len;
        return r;
    endfunction

    // One field compare; X on the output counts as a mismatch
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            if (fail_count < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            fail_count++;
        end
    endtask

    // Predict on every accepted byte, compare on every accepted status beat
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            head_val      = 8'h00;
            tail_val      = 8'h00;
            phase         = PH_HEAD;
            byte_cnt      = 16'h0000;
            decl_len      = 16'h0000;
            sender        = 4'h0;
            status_due.delete();
            fail_count    = 0;
            pending       = 0;
            beats_checked = 0;
            done_count    = 0;
            err_count     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_HEAD)
                    head_val = cfg_data;
                else
                    tail_val = cfg_data;
            end
            if (in_mon.valid && in_mon.ready)
                status_due.push_back(parse_byte(in_mon.rx_byte));
            if (out_mon.valid && out_mon.ready)
            begin
                got.status        = out_mon.status;
                got.sender_id     = out_mon.sender_id;
                got.frame_length  = out_mon.frame_length;
                got.byte_value    = out_mon.byte_value;
                got.payload_index = out_mon.payload_index;
                if (status_due.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t ns: unexpected status beat, expected none, actual %p",
                                 $time, got);
                    fail_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("sender_id", 16'(want.sender_id), 16'(got.sender_id));
                    check_field("frame_length", want.frame_length, got.frame_length);
                    check_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
                    check_field("payload_index", want.payload_index, got.payload_index);
                    beats_checked++;
                    if (want.status == ST_DONE)
                        done_count++;
                    if (want.status == ST_HEAD_ERR || want.status == ST_CTRL_ERR ||
                        want.status == ST_TAIL_ERR)
                        err_count++;
                end
            end
            pending = status_due.size();
        end
    end

endmodule

[tb/byte_frame_deframer_tb.sv]
// Testbench top: clock, reset, framed byte stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module byte_frame_deframer_tb;
    import bfd_pkg::*;

    typedef enum {FRAME_OK, FRAME_CTRL_ERR, FRAME_TAIL_ERR} frame_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int beats_checked;
    int done_count;
    int err_count;

    // Stimulus bookkeeping
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned settings_cnt = 0;
    int unsigned rx_cycle     = 0;
    int unsigned stall_mode   = 0;
    logic [7:0]  cur_head     = 8'h00;
    logic [7:0]  cur_tail     = 8'h00;

    bfd_in_if  in_ch ();
    bfd_out_if out_ch ();

    byte_frame_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    bfd_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .done_count    (done_count),
        .err_count     (err_count)
    );

    always #4 clk = ~clk;

    // Receiver: stall pattern changes whenever the low byte of the cycle counter is zero
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       out_ch.ready <= (rx_cycle[1:0] == 2'd0);
            default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Send one byte; bursts of random length with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every predicted beat has come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_framing(input logic [7:0] h, input logic [7:0] t);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEAD;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_TAIL;
        cfg_data  <= t;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_head = h;
        cur_tail = t;
        settings_cnt++;
    endtask

    // Whole frame with random content; the kind picks where it breaks
    task automatic send_frame(input frame_kind_t kind, input logic [15:0] len);
        logic [7:0]  ctrl;
        logic [7:0]  tl;
        int unsigned k;
        ctrl      = 8'($urandom);
        ctrl[7:4] = 4'($urandom_range(1, 15));
        send_byte(cur_head);
        if (kind == FRAME_CTRL_ERR)
        begin
            ctrl[7:4] = 4'h0;
            send_byte(ctrl);
            return;
        end
        send_byte(ctrl);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (k = 0; k < len; k++)
            send_byte(8'($urandom));
        send_byte(8'($urandom));  // check byte, never tested
        tl = cur_tail;
        if (kind == FRAME_TAIL_ERR)
            tl = cur_tail ^ 8'($urandom_range(1, 255));
        send_byte(tl);
    endtask

    // Mostly well-formed frames, some broken ones, some stray bytes
    task automatic run_random(input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        int unsigned r;
        int unsigned n;
        logic [15:0] len;
        logic [7:0]  nb;
        start = bytes_sent;
        while (bytes_sent - start < quota)
        begin
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            if (r < 12)
                len = 16'd0;
            else if (r < 75)
                len = 16'($urandom_range(1, 8));
            else if (r < 99)
                len = 16'($urandom_range(9, 40));
            else
                len = 16'($urandom_range(256, 270));
            if (pick < 70)
                send_frame(FRAME_OK, len);
            else if (pick < 80)
                send_frame(FRAME_CTRL_ERR, len);
            else if (pick < 88)
                send_frame(FRAME_TAIL_ERR, len);
            else
            begin
                // stray bytes between frames, kept off the head value
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    do
                        nb = 8'($urandom);
                    while (nb == cur_head);
                    send_byte(nb);
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_HEAD;
        cfg_data      = 8'h00;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = 8'h00;
        out_ch.ready  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, with head and tail at their reset value of zero
        send_byte(8'hFF);                    // head error
        send_byte(8'h00);                    // two-byte frame, sender 0xF
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);                    // command byte
        send_byte(8'h00);                    // payload byte
        send_byte(8'h55);                    // check
        send_byte(8'h00);                    // tail ok
        send_byte(8'h00);                    // head reports the old length
        send_byte(8'h0F);                    // control error: zero type nibble
        send_byte(8'h00);                    // empty frame, lowest type nibble
        send_byte(8'h10);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hAA);                    // taken as check right after length
        send_byte(8'h7E);                    // tail error
        send_byte(8'h00);                    // one-byte frame, command only
        send_byte(8'h8C);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'h00);

        // Random phases over several framing settings
        set_framing(8'h7E, 8'h7E);
        run_random(310);
        set_framing(8'hFF, 8'h00);
        run_random(310);
        set_framing(8'h00, 8'hFF);
        run_random(310);
        set_framing(8'hA5, 8'h5A);
        run_random(310);
        set_framing(8'($urandom), 8'($urandom));
        run_random(310);
        set_framing(8'($urandom), 8'($urandom));
        run_random(310);

        wait_idle();
        repeat (4) @(posedge clk);
        $display("Sent %0d bytes across %0d head/tail settings, with long frames and stalls.",
                 bytes_sent, settings_cnt + 1);
        $display("Checked %0d status beats: %0d frames completed, %0d framing errors reported.",
                 beats_checked, done_count, err_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
